/* src/mavg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average package
// Shared sizes, sequencer states and divider request/response types.
// ----------------------------------------------------------------------------
package mavg_pkg;

	// Window depth and sample format
	localparam int WINDOW      = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int AVG_W       = 24;

	// Derived widths
	localparam int PTR_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
	localparam int MAG_W  = SUM_W + FRAC_BITS;
	localparam int ITER_W = $clog2(MAG_W);

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV
	} state_t;

	// Divider start request
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	// Divider status and result
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [MAG_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* src/moving_average_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter
// Sliding-window mean over the last WINDOW samples, 8 fraction bits.
// ----------------------------------------------------------------------------
// Accepted sample: ST_READ, then ST_DIV until the bit-serial divider is done and
// the output reg is free; in_stall holds off a new sample until the result loads.
// A new item is taken while the previous result still waits in the output reg.
// Reset clears ring pointer, count, running sum and handshake state at once;
// unwritten ring entries read as zero through the fill count, no clear pass.
// ----------------------------------------------------------------------------
module moving_average_filter (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [mavg_pkg::SAMPLE_BITS-1:0]  sample,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [mavg_pkg::AVG_W-1:0]        average,
	output logic                                     window_full
);

	mavg_pkg::state_t                         state_q, state_d;
	logic [mavg_pkg::PTR_W-1:0]               pos_q;
	logic [mavg_pkg::CNT_W-1:0]               cnt_q;
	logic signed [mavg_pkg::SUM_W-1:0]        sum_q;
	logic signed [mavg_pkg::SAMPLE_BITS-1:0]  sample_q;
	logic                                     neg_q;
	logic                                     out_valid_q;
	logic signed [mavg_pkg::AVG_W-1:0]        average_q;
	logic                                     full_q;

	logic                                     in_acc;
	logic                                     out_free;
	logic                                     load_out;
	logic                                     ring_full;
	logic [mavg_pkg::SAMPLE_BITS-1:0]         ring_rdata;
	logic signed [mavg_pkg::SAMPLE_BITS-1:0]  old_s;
	logic signed [mavg_pkg::SUM_W-1:0]        sum_nx;
	logic [mavg_pkg::SUM_W-1:0]               sum_abs;
	logic [mavg_pkg::CNT_W-1:0]               cnt_nx;
	logic [mavg_pkg::PTR_W-1:0]               pos_nx;
	logic signed [mavg_pkg::MAG_W:0]          res_s;

	mavg_pkg::div_req_t                       div_req;
	mavg_pkg::div_rsp_t                       div_rsp;

	// Handshake
	assign in_stall = (state_q != mavg_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == mavg_pkg::ST_DIV) && div_rsp.done && out_free;

	// Sample ring: read old entry on accept, write new sample in ST_READ, the cycle after
	mavg_ring u_ring (
		.clk   (clk),
		.we    (state_q == mavg_pkg::ST_READ),
		.waddr (pos_q),
		.wdata (sample_q),
		.re    (in_acc),
		.raddr (pos_q),
		.rdata (ring_rdata)
	);

	// Running sum update; entries not yet written count as zero
	always_comb begin
		ring_full = (cnt_q == mavg_pkg::CNT_W'(mavg_pkg::WINDOW));
		old_s     = ring_full ? $signed(ring_rdata) : '0;
		sum_nx    = sum_q + mavg_pkg::SUM_W'(sample_q) - mavg_pkg::SUM_W'(old_s);
		sum_abs   = sum_nx[mavg_pkg::SUM_W-1] ? mavg_pkg::SUM_W'(-sum_nx)
		                                      : mavg_pkg::SUM_W'(sum_nx);
		cnt_nx    = ring_full ? cnt_q : cnt_q + 1'b1;
		pos_nx    = (pos_q == mavg_pkg::PTR_W'(mavg_pkg::WINDOW - 1)) ? '0
		                                                            : pos_q + 1'b1;
	end

	// Divider request: |sum| scaled by 2^FRAC_BITS over the sample count
	always_comb begin
		div_req.start    = (state_q == mavg_pkg::ST_READ);
		div_req.dividend = {sum_abs, {mavg_pkg::FRAC_BITS{1'b0}}};
		div_req.divisor  = cnt_nx;
	end

	mavg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Reapply the sign; quotient truncates toward zero
	assign res_s = neg_q ? -$signed({1'b0, div_rsp.quotient})
	                     : $signed({1'b0, div_rsp.quotient});

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mavg_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = mavg_pkg::ST_READ;
				end
			end
			mavg_pkg::ST_READ: begin
				state_d = mavg_pkg::ST_DIV;
			end
			mavg_pkg::ST_DIV: begin
				if (load_out) begin
					state_d = mavg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mavg_pkg::ST_IDLE;
			end
		endcase
	end

	// State register and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mavg_pkg::ST_IDLE;
			pos_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mavg_pkg::ST_READ) begin
				pos_q <= pos_nx;
				cnt_q <= cnt_nx;
				sum_q <= sum_nx;
			end
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
		end
		if (state_q == mavg_pkg::ST_READ) begin
			neg_q <= sum_nx[mavg_pkg::SUM_W-1];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			average_q <= mavg_pkg::AVG_W'(res_s);
			full_q    <= ring_full;
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = average_q;
	assign window_full = full_q;

	// Accepted item goes straight to the ring read cycle
	a_acc_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == mavg_pkg::ST_READ)
		else $error("accept did not start ring read");

	// Sample count saturates at the window depth
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mavg_pkg::CNT_W'(mavg_pkg::WINDOW))
		else $error("sample count beyond window");

	// A result held by the consumer keeps the sequencer waiting
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mavg_pkg::ST_DIV && out_valid_q && out_stall
			|=> state_q == mavg_pkg::ST_DIV && out_valid_q)
		else $error("result overwritten while stalled");

	// Divider is always running or done while waiting on it
	a_div_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mavg_pkg::ST_DIV |-> div_rsp.busy || div_rsp.done)
		else $error("divider idle during divide state");

endmodule

/* src/mavg_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average sample ring
// Single-port-write, single-port-read sample store with registered read data.
// ----------------------------------------------------------------------------
module mavg_ring (
	input  logic                               clk,
	input  logic                               we,
	input  logic [mavg_pkg::PTR_W-1:0]         waddr,
	input  logic [mavg_pkg::SAMPLE_BITS-1:0]   wdata,
	input  logic                               re,
	input  logic [mavg_pkg::PTR_W-1:0]         raddr,
	output logic [mavg_pkg::SAMPLE_BITS-1:0]   rdata
);

	logic [mavg_pkg::SAMPLE_BITS-1:0] mem_q [mavg_pkg::WINDOW];
	logic [mavg_pkg::SAMPLE_BITS-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/mavg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mavg_pkg::div_req_t  req,
	output mavg_pkg::div_rsp_t  rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [mavg_pkg::ITER_W-1:0]       iter_q;
	logic [mavg_pkg::MAG_W-1:0]        quo_q;
	logic [mavg_pkg::CNT_W:0]          rem_q;
	logic [mavg_pkg::CNT_W-1:0]        dvs_q;

	logic [mavg_pkg::CNT_W:0]          rem_sh;
	logic [mavg_pkg::CNT_W:0]          rem_diff;
	logic                              fits;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		rem_sh   = {rem_q[mavg_pkg::CNT_W-1:0], quo_q[mavg_pkg::MAG_W-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		fits     = (rem_sh >= {1'b0, dvs_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= mavg_pkg::ITER_W'(mavg_pkg::MAG_W - 1);
		end else if (busy_q) begin
			if (iter_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				iter_q <= iter_q - 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mavg_pkg::MAG_W-2:0], fits};
			rem_q <= fits ? rem_diff : rem_sh;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// A new division never starts on top of one in flight
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	// Divisor is a sample count, never zero
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> req.divisor != '0)
		else $error("divide by zero");

	// Finishing drops busy and raises done together
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && iter_q == '0 && !req.start |=> done_q && !busy_q)
		else $error("divider finish sequence broken");

endmodule
